// ----- hw/rtl/ntc_pkg.sv -----
`timescale 1ns / 1ps

package ntc_pkg;

  localparam int unsigned WindowDefault = 8;

  localparam int unsigned AdcW  = 10;
  localparam int unsigned TempW = 18;
  localparam int unsigned CfgW  = 20;

  localparam int unsigned NormSteps = 5;
  localparam int unsigned SqSteps   = 24;
  localparam int unsigned DivSteps  = 17;

  localparam logic [29:0] Ln2Q30 = 30'd744261118;

  localparam logic signed [TempW-1:0] TempMax = 18'sd100000;
  localparam logic signed [TempW-1:0] TempMin = -18'sd27315;
  localparam logic signed [TempW-1:0] ZeroCk  = 18'sd27315;
  localparam logic [16:0]             TkMax   = 17'd127315;

  localparam logic [1:0] CfgNominal = 2'd0;
  localparam logic [1:0] CfgRefTemp = 2'd1;
  localparam logic [1:0] CfgBeta    = 2'd2;
  localparam logic [1:0] CfgSeries  = 2'd3;

  typedef struct packed {
    logic [19:0] nominal;
    logic [15:0] ref_temp;
    logic [14:0] beta;
    logic [19:0] series;
  } cfg_t;

  typedef struct packed {
    logic       load;
    logic       norm;
    logic [2:0] norm_step;
    logic       square;
    logic       diff;
    logic       ln_mul;
    logic       den_mul;
    logic       den_sum;
    logic       div_init;
    logic       div_step;
    logic       finish;
    logic       commit;
    logic       avg_mul;
    logic       push;
  } cmd_t;

  typedef struct packed {
    logic out_free;
  } status_t;

endpackage

// ----- hw/rtl/ntc_ctrl.sv -----
`timescale 1ns / 1ps

module ntc_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  ntc_pkg::status_t status_i,
  output ntc_pkg::cmd_t   cmd_o
);
  import ntc_pkg::*;

  localparam logic [3:0] StIdle    = 4'd0;
  localparam logic [3:0] StNorm    = 4'd1;
  localparam logic [3:0] StSquare  = 4'd2;
  localparam logic [3:0] StDiff    = 4'd3;
  localparam logic [3:0] StLnMul   = 4'd4;
  localparam logic [3:0] StDenMul  = 4'd5;
  localparam logic [3:0] StDenSum  = 4'd6;
  localparam logic [3:0] StDivInit = 4'd7;
  localparam logic [3:0] StDivStep = 4'd8;
  localparam logic [3:0] StFinish  = 4'd9;
  localparam logic [3:0] StCommit  = 4'd10;
  localparam logic [3:0] StAvgMul  = 4'd11;
  localparam logic [3:0] StOutput  = 4'd12;

  logic [3:0] state_q, state_d;
  logic [4:0] cnt_q, cnt_d;

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          cnt_d      = '0;
          state_d    = StNorm;
        end
      end
      StNorm: begin
        cmd_o.norm      = 1'b1;
        cmd_o.norm_step = cnt_q[2:0];
        if (cnt_q == 5'(NormSteps - 1)) begin
          cnt_d   = '0;
          state_d = StSquare;
        end else begin
          cnt_d = cnt_q + 5'd1;
        end
      end
      StSquare: begin
        cmd_o.square = 1'b1;
        if (cnt_q == 5'(SqSteps - 1)) begin
          cnt_d   = '0;
          state_d = StDiff;
        end else begin
          cnt_d = cnt_q + 5'd1;
        end
      end
      StDiff: begin
        cmd_o.diff = 1'b1;
        state_d    = StLnMul;
      end
      StLnMul: begin
        cmd_o.ln_mul = 1'b1;
        state_d      = StDenMul;
      end
      StDenMul: begin
        cmd_o.den_mul = 1'b1;
        state_d       = StDenSum;
      end
      StDenSum: begin
        cmd_o.den_sum = 1'b1;
        state_d       = StDivInit;
      end
      StDivInit: begin
        cmd_o.div_init = 1'b1;
        cnt_d          = '0;
        state_d        = StDivStep;
      end
      StDivStep: begin
        cmd_o.div_step = 1'b1;
        if (cnt_q == 5'(DivSteps - 1)) begin
          cnt_d   = '0;
          state_d = StFinish;
        end else begin
          cnt_d = cnt_q + 5'd1;
        end
      end
      StFinish: begin
        cmd_o.finish = 1'b1;
        state_d      = StCommit;
      end
      StCommit: begin
        cmd_o.commit = 1'b1;
        state_d      = StAvgMul;
      end
      StAvgMul: begin
        cmd_o.avg_mul = 1'b1;
        state_d       = StOutput;
      end
      StOutput: begin
        if (status_i.out_free) begin
          cmd_o.push = 1'b1;
          state_d    = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

// ----- hw/rtl/ntc_dp.sv -----
`timescale 1ns / 1ps

module ntc_dp #(
  parameter int unsigned Window = ntc_pkg::WindowDefault
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  ntc_pkg::cfg_t                     cfg_i,
  input  ntc_pkg::cmd_t                     cmd_i,
  input  logic [ntc_pkg::AdcW-1:0]          adc_code_i,
  output logic signed [ntc_pkg::TempW-1:0]  sample_o,
  output logic signed [ntc_pkg::TempW-1:0]  avg_o
);
  import ntc_pkg::*;

  localparam int unsigned Lg     = $clog2(Window);
  localparam int unsigned PosW   = (Window > 1) ? Lg : 1;
  localparam int unsigned SumW   = TempW + Lg;
  localparam int unsigned Shift  = SumW + Lg;
  localparam int unsigned RecipW = Shift + 1;
  localparam logic [63:0] RecipM =
    ((64'd1 << Shift) + 64'(Window) - 64'd1) / 64'(Window);

  function automatic logic [35:0] norm_fn(logic [30:0] m, logic [4:0] top, logic [2:0] step);
    logic [30:0] mo;
    logic [4:0]  to;
    mo = m;
    to = top;
    case (step)
      3'd0: if (m[30:15] == '0) begin mo = m << 16; to = top - 5'd16; end
      3'd1: if (m[30:23] == '0) begin mo = m << 8;  to = top - 5'd8;  end
      3'd2: if (m[30:27] == '0) begin mo = m << 4;  to = top - 5'd4;  end
      3'd3: if (m[30:29] == '0) begin mo = m << 2;  to = top - 5'd2;  end
      3'd4: if (!m[30])         begin mo = m << 1;  to = top - 5'd1;  end
      default: begin
        mo = m;
        to = top;
      end
    endcase
    return {to, mo};
  endfunction

  function automatic logic [31:0] square_fn(logic [30:0] m);
    logic [61:0] sq;
    logic [31:0] s;
    sq = m * m;
    s  = sq[61:30];
    return s[31] ? {1'b1, s[31:1]} : {1'b0, s[30:0]};
  endfunction

  // log2 stage
  logic [30:0] ma_q, mb_q;
  logic [4:0]  topa_q, topb_q;
  logic [23:0] fa_q, fb_q;
  logic        az_q, bz_q;

  logic [10:0] code_rev;
  logic [30:0] a_prod;
  logic [29:0] b_prod, a_sel, b_sel;
  logic        low_code;
  logic [35:0] norm_a, norm_b;
  logic [31:0] sq_a, sq_b;

  assign low_code = (adc_code_i[9:2] == '0);
  assign code_rev = 11'd1024 - {1'b0, adc_code_i};
  assign a_prod   = cfg_i.series * code_rev;
  assign b_prod   = adc_code_i * cfg_i.nominal;
  assign a_sel    = low_code ? 30'd1000 : a_prod[29:0];
  assign b_sel    = low_code ? 30'd1 : b_prod;
  assign norm_a   = norm_fn(ma_q, topa_q, cmd_i.norm_step);
  assign norm_b   = norm_fn(mb_q, topb_q, cmd_i.norm_step);
  assign sq_a     = square_fn(ma_q);
  assign sq_b     = square_fn(mb_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      ma_q   <= {1'b0, a_sel};
      mb_q   <= {1'b0, b_sel};
      topa_q <= 5'd30;
      topb_q <= 5'd30;
      az_q   <= (a_sel == '0);
      bz_q   <= (b_sel == '0);
    end else if (cmd_i.norm) begin
      {topa_q, ma_q} <= norm_a;
      {topb_q, mb_q} <= norm_b;
    end else if (cmd_i.square) begin
      ma_q <= sq_a[30:0];
      mb_q <= sq_b[30:0];
      fa_q <= {fa_q[22:0], sq_a[31]};
      fb_q <= {fb_q[22:0], sq_b[31]};
    end
  end

  // log ratio, beta equation terms
  logic signed [29:0] d_val;
  logic [29:0]        d_neg;
  logic [28:0]        mag_q;
  logic               neg_q;
  logic [58:0]        ln_prod;
  logic signed [29:0] ln_q;
  logic signed [46:0] tl_q;
  logic [30:0]        nb_q;
  logic [21:0]        b100;
  logic [37:0]        n100;
  logic signed [47:0] den_q;
  logic [61:0]        num_q;

  assign d_val   = $signed({1'b0, topa_q, fa_q}) - $signed({1'b0, topb_q, fb_q});
  assign d_neg   = -d_val;
  assign ln_prod = mag_q * Ln2Q30;
  assign b100    = cfg_i.beta * 7'd100;
  assign n100    = nb_q * 7'd100;

  always_ff @(posedge clk_i) begin
    if (cmd_i.diff) begin
      neg_q <= d_val[29];
      mag_q <= d_val[29] ? d_neg[28:0] : d_val[28:0];
    end
    if (cmd_i.ln_mul) begin
      ln_q <= neg_q ? -$signed({1'b0, ln_prod[58:30]}) : $signed({1'b0, ln_prod[58:30]});
    end
    if (cmd_i.den_mul) begin
      tl_q <= $signed({1'b0, cfg_i.ref_temp}) * ln_q;
      nb_q <= cfg_i.ref_temp * cfg_i.beta;
    end
    if (cmd_i.den_sum) begin
      den_q <= $signed({2'b00, b100, 24'd0}) + $signed({tl_q[46], tl_q});
      num_q <= {n100, 24'd0};
    end
  end

  // restoring divider, quotient limited to 17 bits
  logic [61:0] rem_q;
  logic [62:0] dv_q;
  logic [16:0] quo_q;
  logic        den_ok_q, ovf_q, ge;

  assign ge = ({1'b0, rem_q} >= dv_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_init) begin
      den_ok_q <= !den_q[47] && (den_q != '0);
      ovf_q    <= ({2'b00, num_q} >= {den_q[46:0], 17'd0});
      rem_q    <= num_q;
      dv_q     <= {den_q[46:0], 16'd0};
      quo_q    <= '0;
    end else if (cmd_i.div_step) begin
      if (ge) begin
        rem_q <= rem_q - dv_q[61:0];
      end
      quo_q <= {quo_q[15:0], ge};
      dv_q  <= dv_q >> 1;
    end
  end

  logic signed [TempW-1:0] sample_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      if (az_q) begin
        sample_q <= TempMax;
      end else if (bz_q) begin
        sample_q <= TempMin;
      end else if (!den_ok_q || ovf_q || (quo_q > TkMax)) begin
        sample_q <= TempMax;
      end else begin
        sample_q <= $signed({1'b0, quo_q}) - ZeroCk;
      end
    end
  end

  // sample ring and running sum
  logic signed [TempW-1:0] ring_mem [Window];
  logic signed [TempW-1:0] ring_rd_q;
  logic [Window-1:0]       ring_vld_q;
  logic                    old_vld_q;
  logic [PosW-1:0]         pos_q;
  logic signed [SumW-1:0]  sum_q;
  logic signed [TempW-1:0] old_val;

  assign old_val = old_vld_q ? ring_rd_q : '0;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      ring_rd_q <= ring_mem[pos_q];
    end
    if (cmd_i.commit) begin
      ring_mem[pos_q] <= sample_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ring_vld_q <= '0;
      old_vld_q  <= 1'b0;
      pos_q      <= '0;
      sum_q      <= '0;
    end else begin
      if (cmd_i.load) begin
        old_vld_q <= ring_vld_q[pos_q];
      end
      if (cmd_i.commit) begin
        ring_vld_q[pos_q] <= 1'b1;
        sum_q <= sum_q - SumW'(old_val) + SumW'(sample_q);
        if (pos_q == PosW'(Window - 1)) begin
          pos_q <= '0;
        end else begin
          pos_q <= pos_q + PosW'(1);
        end
      end
    end
  end

  // average by reciprocal multiply
  logic [SumW-1:0]        sum_abs;
  logic [SumW-1:0]        sum_neg;
  logic [RecipW-1:0]      recip;
  logic [SumW+RecipW-1:0] avg_prod;
  logic [TempW-1:0]       avg_mag_q;
  logic                   avg_neg_q;

  assign sum_neg  = -sum_q;
  assign sum_abs  = sum_q[SumW-1] ? sum_neg : sum_q;
  assign recip    = RecipM[RecipW-1:0];
  assign avg_prod = sum_abs * recip;

  always_ff @(posedge clk_i) begin
    if (cmd_i.avg_mul) begin
      avg_mag_q <= avg_prod[Shift +: TempW];
      avg_neg_q <= sum_q[SumW-1];
    end
  end

  assign sample_o = sample_q;
  assign avg_o    = avg_neg_q ? -$signed(avg_mag_q) : $signed(avg_mag_q);

endmodule

// ----- hw/rtl/ntc_thermistor_temperature_filter_top.sv -----
`timescale 1ns / 1ps

// NTC thermistor temperature with moving average. Each input transaction
// carries a 10-bit converter code; one output transaction returns the
// sample temperature and the average over the last Window samples, both in
// 0.01 degC, signed 18 bit. The ring starts at zero after reset, so early
// averages ramp up. Each item passes from acceptance to a valid result through
// 5 normalize steps, the 24-step squaring loop of the log2 unit, the 17-step
// restoring divider and 9 further steps. The block takes no new item while
// one is in flight: the next is taken in the cycle after the result moves
// into the output register, and a full output register that is not being
// read holds that move back. Write registers only while the block is idle.
module ntc_thermistor_temperature_filter_top #(
  parameter int unsigned Window = ntc_pkg::WindowDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [9:0] adc_code
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // [17:0] sample_temp, [35:18] average_temp
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [19:0] cfg_data_i
);
  import ntc_pkg::*;

  cfg_t    cfg_q;
  cmd_t    cmd;
  status_t status;

  logic signed [TempW-1:0] sample_val, avg_val;
  logic signed [TempW-1:0] out_sample_q, out_avg_q;
  logic                    out_valid_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.nominal  <= 20'd10000;
      cfg_q.ref_temp <= 16'd29815;
      cfg_q.beta     <= 15'd3950;
      cfg_q.series   <= 20'd10280;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CfgNominal: cfg_q.nominal  <= cfg_data_i;
        CfgRefTemp: cfg_q.ref_temp <= cfg_data_i[15:0];
        CfgBeta:    cfg_q.beta     <= cfg_data_i[14:0];
        CfgSeries:  cfg_q.series   <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  assign status.out_free = !out_valid_q || m_axis_tready;

  ntc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  ntc_dp #(
    .Window (Window)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .cmd_i      (cmd),
    .adc_code_i (s_axis_tdata[AdcW-1:0]),
    .sample_o   (sample_val),
    .avg_o      (avg_val)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd.push) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd.push) begin
      out_sample_q <= sample_val;
      out_avg_q    <= avg_val;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {4'd0, out_avg_q, out_sample_q};

endmodule

// ----- sim/ntc_thermistor_temperature_filter_top_tb.sv -----
`timescale 1ns / 1ps

module ntc_thermistor_temperature_filter_top_tb;
  import ntc_pkg::*;

  typedef struct {
    logic [19:0] nom;
    logic [15:0] t0;
    logic [14:0] beta;
    logic [19:0] ser;
    logic [9:0]  code;
    bit          chk;
    logic signed [17:0] temp;
  } row_t;

  typedef struct {
    logic signed [17:0] sample;
    logic signed [17:0] average;
    bit                 chk;
    logic signed [17:0] typed;
  } temp_pair_t;

  localparam int unsigned WatchLimit = 5000;
  localparam int unsigned HoldCycles = 600;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i = CfgNominal;
  logic [19:0] cfg_data_i = '0;

  ntc_thermistor_temperature_filter_top i_dut (.*);

  always #4 clk_i = ~clk_i;

  logic [19:0] nom_q = 20'd10000;
  logic [15:0] t0_q = 16'd29815;
  logic [14:0] beta_q = 15'd3950;
  logic [19:0] ser_q = 20'd10280;
  longint      ring_q[WindowDefault];
  int unsigned ring_pos;
  longint      ring_sum;

  temp_pair_t  temps_due[$];
  int unsigned codes_sent;
  int unsigned results_seen;
  int unsigned mismatches;
  bit          calm;

  function automatic longint unsigned log2_q24(longint unsigned x);
    longint unsigned t, m, frac;
    int unsigned top;
    t = x & 64'h7FFF_FFFF;
    frac = 0;
    top = 0;
    if (t == 0) return 0;
    m = t;
    while (t > 1) begin
      t >>= 1;
      top++;
    end
    m = m << (30 - top);
    for (int i = 0; i < 24; i++) begin
      m = (m * m) >> 30;
      frac <<= 1;
      if (m >= (64'd1 << 31)) begin
        m >>= 1;
        frac |= 1;
      end
    end
    return (longint'(top) << 24) | frac;
  endfunction

  function automatic longint temp_of(logic [9:0] code);
    longint unsigned a, b, mag, num, tk;
    longint d, ln, den;
    if (code <= 3) begin
      a = 1000;
      b = 1;
    end else begin
      a = longint'(ser_q) * (1024 - longint'(code));
      b = longint'(code) * longint'(nom_q);
    end
    if (a == 0) return 100000;
    if (b == 0) return -27315;
    d = longint'(log2_q24(a)) - longint'(log2_q24(b));
    mag = (d < 0) ? -d : d;
    mag = (mag * 64'd744261118) >> 30;
    ln = (d < 0) ? -longint'(mag) : longint'(mag);
    num = (64'd100 * t0_q * beta_q) << 24;
    den = longint'(64'd100 * beta_q * (64'd1 << 24)) + longint'(t0_q) * ln;
    if (den <= 0) return 100000;
    tk = num / longint'(den);
    if (tk > 127315) return 100000;
    return longint'(tk) - 27315;
  endfunction

  task automatic predict(logic [9:0] code, bit chk, logic signed [17:0] typed);
    temp_pair_t e;
    longint s;
    s = temp_of(code);
    ring_sum -= ring_q[ring_pos];
    ring_q[ring_pos] = s;
    ring_sum += s;
    ring_pos = (ring_pos + 1) % WindowDefault;
    e.sample = s[17:0];
    e.average = 18'(ring_sum / longint'(WindowDefault));
    e.chk = chk;
    e.typed = typed;
    temps_due.push_back(e);
  endtask

  task automatic send_code(logic [9:0] code, bit chk, logic signed [17:0] typed);
    while (!calm && $urandom_range(99) < 13) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {6'd0, code};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    predict(code, chk, typed);
    codes_sent++;
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (temps_due.size() != 0) @(posedge clk_i);
    repeat (70) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [19:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
  endtask

  task automatic set_regs(logic [19:0] nom, logic [15:0] t0, logic [14:0] beta,
                          logic [19:0] ser);
    write_reg(CfgNominal, nom);
    write_reg(CfgRefTemp, 20'(t0));
    write_reg(CfgBeta, 20'(beta));
    write_reg(CfgSeries, ser);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
    nom_q = nom;
    t0_q = t0;
    beta_q = beta;
    ser_q = ser;
  endtask

  function automatic logic [19:0] pick(logic [19:0] lo, logic [19:0] hi,
                                       logic [19:0] mask);
    case ($urandom_range(7))
      0: return 20'd0;
      1: return mask;
      2: return lo;
      3: return hi;
      default: return 20'($urandom_range(hi, lo));
    endcase
  endfunction

  row_t rows[$] = '{
    '{20'd10000, 16'd29815, 15'd3950, 20'd10280, 10'd0,    1'b0, 18'sd0},
    '{20'd10000, 16'd29815, 15'd3950, 20'd10280, 10'd1,    1'b0, 18'sd0},
    '{20'd10000, 16'd29815, 15'd3950, 20'd10280, 10'd3,    1'b0, 18'sd0},
    '{20'd10000, 16'd29815, 15'd3950, 20'd10280, 10'd4,    1'b0, 18'sd0},
    '{20'd10000, 16'd29815, 15'd3950, 20'd10280, 10'd5,    1'b0, 18'sd0},
    '{20'd10000, 16'd29815, 15'd3950, 20'd10280, 10'd512,  1'b0, 18'sd0},
    '{20'd10000, 16'd29815, 15'd3950, 20'd10280, 10'h2AA,  1'b0, 18'sd0},
    '{20'd10000, 16'd29815, 15'd3950, 20'd10280, 10'h155,  1'b0, 18'sd0},
    '{20'd10000, 16'd29815, 15'd3950, 20'd10280, 10'd1000, 1'b0, 18'sd0},
    '{20'd10000, 16'd29815, 15'd3950, 20'd10280, 10'd1023, 1'b0, 18'sd0},
    '{20'd10000, 16'd29815, 15'd3950, 20'd0,     10'd4,    1'b1, 18'sd100000},
    '{20'd10000, 16'd29815, 15'd3950, 20'd0,     10'd1023, 1'b1, 18'sd100000},
    '{20'd10000, 16'd29815, 15'd3950, 20'd0,     10'd0,    1'b0, 18'sd0},
    '{20'd0,     16'd29815, 15'd3950, 20'd10280, 10'd4,    1'b1, -18'sd27315},
    '{20'd0,     16'd29815, 15'd3950, 20'd10280, 10'd1023, 1'b1, -18'sd27315},
    '{20'd0,     16'd29815, 15'd3950, 20'd10280, 10'd3,    1'b0, 18'sd0},
    '{20'd10000, 16'd0,     15'd0,    20'd10280, 10'd512,  1'b1, 18'sd100000},
    '{20'd10000, 16'd29815, 15'd0,    20'd10280, 10'd512,  1'b1, -18'sd27315},
    '{20'hFFFFF, 16'hFFFF,  15'h7FFF, 20'hFFFFF, 10'd4,    1'b0, 18'sd0},
    '{20'hFFFFF, 16'hFFFF,  15'h7FFF, 20'hFFFFF, 10'd1023, 1'b0, 18'sd0},
    '{20'd1,     16'd20000, 15'd1,    20'hFFFFF, 10'd4,    1'b0, 18'sd0},
    '{20'hFFFFF, 16'd40000, 15'd20000, 20'd1,    10'd1023, 1'b0, 18'sd0}
  };

  always @(posedge clk_i) begin : result_check
    temp_pair_t e;
    logic signed [17:0] got_s, got_a;
    if (m_axis_tvalid && m_axis_tready) begin
      got_s = m_axis_tdata[17:0];
      got_a = m_axis_tdata[35:18];
      results_seen++;
      if (temps_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result s=%0d a=%0d", got_s, got_a);
      end else begin
        e = temps_due.pop_front();
        if (got_s !== e.sample || got_a !== e.average ||
            (e.chk && got_s !== e.typed)) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch #%0d: sample exp %0d (table %0d) got %0d, average exp %0d got %0d",
                     results_seen, e.sample, e.chk ? e.typed : e.sample, got_s,
                     e.average, got_a);
        end
      end
    end
  end

  initial begin : sink
    int unsigned hold;
    bit held;
    hold = 0;
    held = 0;
    wait (rst_ni);
    forever begin
      @(posedge clk_i);
      if (!held && codes_sent >= 300) begin
        held = 1;
        hold = HoldCycles;
      end
      if (hold != 0) begin
        hold--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= calm || ($urandom_range(99) >= 13);
      end
    end
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    forever begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (cfg_valid_i && cfg_ready_o))
        quiet = 0;
      else
        quiet++;
      if (quiet >= WatchLimit) begin
        $display("watchdog: no transaction for %0d cycles", quiet);
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  initial begin : stim
    logic [9:0] code;
    for (int i = 0; i < WindowDefault; i++) ring_q[i] = 0;
    ring_pos = 0;
    ring_sum = 0;
    codes_sent = 0;
    results_seen = 0;
    mismatches = 0;
    calm = 0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (rows[i]) begin
      if (rows[i].nom != nom_q || rows[i].t0 != t0_q || rows[i].beta != beta_q ||
          rows[i].ser != ser_q) begin
        drain();
        set_regs(rows[i].nom, rows[i].t0, rows[i].beta, rows[i].ser);
      end
      send_code(rows[i].code, rows[i].chk, rows[i].temp);
    end

    for (int ph = 0; ph < 10; ph++) begin
      drain();
      if (ph == 0)
        set_regs(20'd10000, 16'd29815, 15'd3950, 20'd10280);
      else
        set_regs(pick(20'd1, 20'd1000000, 20'hFFFFF),
                 16'(pick(20'd20000, 20'd40000, 20'hFFFF)),
                 15'(pick(20'd1, 20'd20000, 20'h7FFF)),
                 pick(20'd1, 20'd1000000, 20'hFFFFF));
      for (int k = 0; k < 110; k++) begin
        calm = (codes_sent >= 600 && codes_sent < 800);
        case ($urandom_range(9))
          0: code = 10'($urandom_range(3));
          1: code = 10'($urandom_range(1023, 1016));
          default: code = 10'($urandom_range(1023));
        endcase
        send_code(code, 1'b0, 18'sd0);
      end
    end
    calm = 0;
    drain();
    repeat (100) @(posedge clk_i);

    $display("%0d codes sent over directed and random register settings, %0d results checked",
             codes_sent, results_seen);
    $display("includes low codes, zero registers, register extremes, output stall");
    if (mismatches == 0 && temps_due.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("%0d mismatches, %0d results missing", mismatches, temps_due.size());
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
